/* rtl/mlr_pkg.sv */
// Package for the midpoint line rasterizer: widths, line case and function codes,
// and the beat types for the input, output and internal command queue.
// No dependencies.
`timescale 1ns / 1ps

package mlr_pkg;

  localparam int CoordW = 12;
  localparam int DeltaW = CoordW + 1;
  localparam int DecW   = CoordW + 4;
  localparam int ColorW = 24;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  localparam logic [1:0] CASE_SHALLOW_RISE = 2'd0;
  localparam logic [1:0] CASE_STEEP_RISE   = 2'd1;
  localparam logic [1:0] CASE_SHALLOW_FALL = 2'd2;
  localparam logic [1:0] CASE_STEEP_FALL   = 2'd3;

  typedef struct packed {
    logic                     func;
    logic signed [CoordW-1:0] from_x;
    logic signed [CoordW-1:0] from_y;
    logic signed [CoordW-1:0] to_x;
    logic signed [CoordW-1:0] to_y;
    logic [ColorW-1:0]        color;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] pixel_x;
    logic signed [CoordW-1:0] pixel_y;
    logic [ColorW-1:0]        pixel_color;
    logic                     pixel_valid;
    logic                     last_pixel;
  } out_item_t;

  // Classified command passed from the front to the back through the queue
  typedef struct packed {
    logic                     func;
    logic [1:0]               line_case;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic signed [DeltaW-1:0] dx;
    logic signed [DeltaW-1:0] dy;
    logic signed [CoordW-1:0] stop_major;
    logic [ColorW-1:0]        color;
  } cmd_t;

endpackage

/* rtl/mlr_front.sv */
// Front of the rasterizer: classifies a start beat into one of four line cases,
// orders the endpoints and forms the ordered deltas. Depends on mlr_pkg.
`timescale 1ns / 1ps

module mlr_front (
  input  mlr_pkg::in_item_t item,
  output mlr_pkg::cmd_t     cmd
);

  localparam int CW = mlr_pkg::CoordW;
  localparam int DW = mlr_pkg::DeltaW;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [DW-1:0] adx;
  logic signed [DW-1:0] ady;
  logic [1:0]           lcase;
  logic                 swap;
  logic signed [CW-1:0] x2;
  logic signed [CW-1:0] y2;

  always_comb begin
    dx  = {item.to_x[CW-1], item.to_x} - {item.from_x[CW-1], item.from_x};
    dy  = {item.to_y[CW-1], item.to_y} - {item.from_y[CW-1], item.from_y};
    adx = dx[DW-1] ? -dx : dx;
    ady = dy[DW-1] ? -dy : dy;

    // Flat lines are shallow rising, vertical lines steep rising
    if (dy == '0) begin
      lcase = mlr_pkg::CASE_SHALLOW_RISE;
    end else if (dx == '0) begin
      lcase = mlr_pkg::CASE_STEEP_RISE;
    end else if (dx[DW-1] == dy[DW-1]) begin
      lcase = (ady <= adx) ? mlr_pkg::CASE_SHALLOW_RISE : mlr_pkg::CASE_STEEP_RISE;
    end else begin
      lcase = (ady <= adx) ? mlr_pkg::CASE_SHALLOW_FALL : mlr_pkg::CASE_STEEP_FALL;
    end

    // Order endpoints so the major axis walks in the case's direction
    case (lcase)
      mlr_pkg::CASE_SHALLOW_RISE: swap = dx[DW-1];
      mlr_pkg::CASE_SHALLOW_FALL: swap = !dx[DW-1] && (dx != '0);
      default:                    swap = dy[DW-1];
    endcase

    x2 = swap ? item.from_x : item.to_x;
    y2 = swap ? item.from_y : item.to_y;

    cmd.func       = item.func;
    cmd.line_case  = lcase;
    cmd.x1         = swap ? item.to_x : item.from_x;
    cmd.y1         = swap ? item.to_y : item.from_y;
    cmd.dx         = swap ? -dx : dx;
    cmd.dy         = swap ? -dy : dy;
    cmd.stop_major = (lcase == mlr_pkg::CASE_SHALLOW_RISE ||
                      lcase == mlr_pkg::CASE_SHALLOW_FALL) ? x2 : y2;
    cmd.color      = item.color;
  end

endmodule

/* rtl/mlr_queue.sv */
// Two-entry command queue between the front and the back of the rasterizer.
// Depends on mlr_pkg for the command type.
`timescale 1ns / 1ps

module mlr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_stall,
  input  mlr_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop,
  output mlr_pkg::cmd_t pop_data
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  mlr_pkg::cmd_t entry [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_stall = (count == CntW'(Depth));
  assign pop_valid  = (count != '0);
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/mlr_back.sv */
// Back of the rasterizer: holds the active line, loads the decision term on a
// start, walks one pixel per step and registers the output beat. Depends on mlr_pkg.
`timescale 1ns / 1ps

module mlr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  mlr_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output mlr_pkg::out_item_t out_data
);

  localparam int CW = mlr_pkg::CoordW;
  localparam int DW = mlr_pkg::DeltaW;
  localparam int EW = mlr_pkg::DecW;

  logic signed [CW-1:0] cur_x, cur_x_next;
  logic signed [CW-1:0] cur_y, cur_y_next;
  logic signed [CW-1:0] stop_major, stop_major_next;
  logic signed [EW-1:0] decision, decision_next;
  logic signed [EW-1:0] inc_diag, inc_diag_next;
  logic signed [EW-1:0] inc_straight, inc_straight_next;
  logic [1:0]           line_case, line_case_next;
  logic [mlr_pkg::ColorW-1:0] line_color, line_color_next;
  logic                 active, active_next;
  mlr_pkg::out_item_t   result;

  logic signed [EW-1:0] dxe;
  logic signed [EW-1:0] dye;
  logic                 diag;
  logic                 at_end;
  logic                 fire;

  assign fire    = cmd_valid && (!out_valid || !out_stall);
  assign cmd_pop = fire;

  always_comb begin
    dxe = {{(EW - DW){cmd.dx[DW-1]}}, cmd.dx};
    dye = {{(EW - DW){cmd.dy[DW-1]}}, cmd.dy};

    cur_x_next        = cur_x;
    cur_y_next        = cur_y;
    stop_major_next   = stop_major;
    decision_next     = decision;
    inc_diag_next     = inc_diag;
    inc_straight_next = inc_straight;
    line_case_next    = line_case;
    line_color_next   = line_color;
    diag              = 1'b0;

    if (cmd.func == mlr_pkg::FUNC_START) begin
      cur_x_next      = cmd.x1;
      cur_y_next      = cmd.y1;
      stop_major_next = cmd.stop_major;
      line_case_next  = cmd.line_case;
      line_color_next = cmd.color;
      case (cmd.line_case)
        mlr_pkg::CASE_SHALLOW_RISE: begin
          decision_next     = dxe - (dye <<< 1);
          inc_diag_next     = (dxe - dye) <<< 1;
          inc_straight_next = -(dye <<< 1);
        end
        mlr_pkg::CASE_STEEP_RISE: begin
          decision_next     = (dxe <<< 1) - dye;
          inc_diag_next     = (dxe - dye) <<< 1;
          inc_straight_next = dxe <<< 1;
        end
        mlr_pkg::CASE_SHALLOW_FALL: begin
          decision_next     = dxe + (dye <<< 1);
          inc_diag_next     = (dxe + dye) <<< 1;
          inc_straight_next = dye <<< 1;
        end
        default: begin
          decision_next     = (dxe <<< 1) + dye;
          inc_diag_next     = (dxe + dye) <<< 1;
          inc_straight_next = dxe <<< 1;
        end
      endcase
    end else if (active) begin
      if (line_case == mlr_pkg::CASE_SHALLOW_RISE || line_case == mlr_pkg::CASE_STEEP_FALL) begin
        diag = (decision <= 0);
      end else begin
        diag = (decision >= 0);
      end
      decision_next = decision + (diag ? inc_diag : inc_straight);
      case (line_case)
        mlr_pkg::CASE_SHALLOW_RISE: begin
          cur_x_next = cur_x + 1'b1;
          cur_y_next = diag ? cur_y + 1'b1 : cur_y;
        end
        mlr_pkg::CASE_STEEP_RISE: begin
          cur_y_next = cur_y + 1'b1;
          cur_x_next = diag ? cur_x + 1'b1 : cur_x;
        end
        mlr_pkg::CASE_SHALLOW_FALL: begin
          cur_x_next = cur_x - 1'b1;
          cur_y_next = diag ? cur_y + 1'b1 : cur_y;
        end
        default: begin
          cur_y_next = cur_y + 1'b1;
          cur_x_next = diag ? cur_x - 1'b1 : cur_x;
        end
      endcase
    end

    at_end = (line_case_next == mlr_pkg::CASE_SHALLOW_RISE ||
              line_case_next == mlr_pkg::CASE_SHALLOW_FALL) ?
             (cur_x_next == stop_major_next) : (cur_y_next == stop_major_next);

    // Step with no line: drop to an all-zero beat and keep state
    if (cmd.func == mlr_pkg::FUNC_STEP && !active) begin
      active_next = active;
      result      = '0;
    end else begin
      active_next        = !at_end;
      result.pixel_x     = cur_x_next;
      result.pixel_y     = cur_y_next;
      result.pixel_color = line_color_next;
      result.pixel_valid = 1'b1;
      result.last_pixel  = at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x        <= '0;
      cur_y        <= '0;
      stop_major   <= '0;
      decision     <= '0;
      inc_diag     <= '0;
      inc_straight <= '0;
      line_case    <= mlr_pkg::CASE_SHALLOW_RISE;
      line_color   <= '0;
      active       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (fire) begin
        cur_x        <= cur_x_next;
        cur_y        <= cur_y_next;
        stop_major   <= stop_major_next;
        decision     <= decision_next;
        inc_diag     <= inc_diag_next;
        inc_straight <= inc_straight_next;
        line_case    <= line_case_next;
        line_color   <= line_color_next;
        active       <= active_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

endmodule

/* rtl/midpoint_line_raster.sv */
// Midpoint line rasterizer top level: front classifier, command queue and back
// stepper. Depends on mlr_pkg, mlr_front, mlr_queue and mlr_back.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): a beat with func = start loads
//   two endpoints and a color and returns the first pixel; a beat with func = step
//   returns the next pixel, with last_pixel set on the final endpoint. A step with
//   no active line returns an all-zero beat (pixel_valid = 0).
//   Output channel (out_valid / out_stall / out_data): exactly one beat per input
//   beat, in order.
//   A beat accepted into the command queue is loaded into the output register
//   when the output is free.
//   Throughput: one beat per clock while the output is not stalled, set by the back
//   stepper, which does one decision add and one endpoint compare per pixel.
//   A stalled receiver holds the output register; the two-entry command queue then
//   fills and in_stall rises once it holds two beats, at most two more beats after
//   the stall began.
//   Reset (rst, synchronous): queue empty, output empty, no line active.
`timescale 1ns / 1ps

module midpoint_line_raster (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mlr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mlr_pkg::out_item_t out_data
);

  mlr_pkg::cmd_t front_cmd;
  mlr_pkg::cmd_t back_cmd;
  logic          back_cmd_valid;
  logic          back_cmd_pop;

  mlr_front u_front (
    .item (in_data),
    .cmd  (front_cmd)
  );

  mlr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .push_data  (front_cmd),
    .pop_valid  (back_cmd_valid),
    .pop        (back_cmd_pop),
    .pop_data   (back_cmd)
  );

  mlr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_cmd_valid),
    .cmd       (back_cmd),
    .cmd_pop   (back_cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the midpoint line rasterizer: a queue-fed driver,
// a checking monitor and a cycle-free pixel predictor for every accepted beat.
// Depends on mlr_pkg and midpoint_line_raster.
`timescale 1ns / 1ps

module tb;

  localparam int CW  = mlr_pkg::CoordW;
  localparam int CLW = mlr_pkg::ColorW;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  mlr_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  mlr_pkg::out_item_t out_data;

  mlr_pkg::in_item_t  raster_cmd_q[$];
  mlr_pkg::out_item_t pixel_q[$];
  int        err_cnt = 0;
  int        src_gap = 0;
  int        snk_gap = 0;

  // Predicted line state
  int               ln_x = 0;
  int               ln_y = 0;
  int               ln_stop = 0;
  int               ln_dec = 0;
  int               ln_inc_diag = 0;
  int               ln_inc_str = 0;
  logic [1:0]       ln_case = mlr_pkg::CASE_SHALLOW_RISE;
  logic [CLW-1:0]   ln_color = '0;
  bit               ln_active = 1'b0;

  always #5 clk = ~clk;

  midpoint_line_raster u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  task automatic trace_pixel(input mlr_pkg::in_item_t beat);
    int                 x1, y1, x2, y2, dx, dy, adx, ady, t;
    bit                 swap, diag, at_stop;
    mlr_pkg::out_item_t px;
    px = '0;
    if (beat.func == mlr_pkg::FUNC_STEP && !ln_active) begin
      pixel_q.push_back(px);
    end else begin
      if (beat.func == mlr_pkg::FUNC_START) begin
        x1 = int'(beat.from_x);
        y1 = int'(beat.from_y);
        x2 = int'(beat.to_x);
        y2 = int'(beat.to_y);
        dx = x2 - x1;
        dy = y2 - y1;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        // flat lines are shallow rising, vertical ones steep rising
        if (dy == 0) ln_case = mlr_pkg::CASE_SHALLOW_RISE;
        else if (dx == 0) ln_case = mlr_pkg::CASE_STEEP_RISE;
        else if ((dx > 0) == (dy > 0))
          ln_case = (ady <= adx) ? mlr_pkg::CASE_SHALLOW_RISE : mlr_pkg::CASE_STEEP_RISE;
        else
          ln_case = (ady <= adx) ? mlr_pkg::CASE_SHALLOW_FALL : mlr_pkg::CASE_STEEP_FALL;
        case (ln_case)
          mlr_pkg::CASE_SHALLOW_RISE: swap = x1 > x2;
          mlr_pkg::CASE_SHALLOW_FALL: swap = x1 < x2;
          default:                    swap = y1 > y2;
        endcase
        if (swap) begin
          t = x1; x1 = x2; x2 = t;
          t = y1; y1 = y2; y2 = t;
        end
        dx = x2 - x1;
        dy = y2 - y1;
        ln_x = x1;
        ln_y = y1;
        case (ln_case)
          mlr_pkg::CASE_SHALLOW_RISE: begin
            ln_dec = dx - 2 * dy; ln_inc_diag = 2 * (dx - dy); ln_inc_str = -2 * dy;
            ln_stop = x2;
          end
          mlr_pkg::CASE_STEEP_RISE: begin
            ln_dec = 2 * dx - dy; ln_inc_diag = 2 * (dx - dy); ln_inc_str = 2 * dx;
            ln_stop = y2;
          end
          mlr_pkg::CASE_SHALLOW_FALL: begin
            ln_dec = dx + 2 * dy; ln_inc_diag = 2 * (dx + dy); ln_inc_str = 2 * dy;
            ln_stop = x2;
          end
          default: begin
            ln_dec = 2 * dx + dy; ln_inc_diag = 2 * (dx + dy); ln_inc_str = 2 * dx;
            ln_stop = y2;
          end
        endcase
        ln_color = beat.color;
      end else begin
        if (ln_case == mlr_pkg::CASE_SHALLOW_RISE || ln_case == mlr_pkg::CASE_STEEP_FALL)
          diag = ln_dec <= 0;
        else
          diag = ln_dec >= 0;
        ln_dec += diag ? ln_inc_diag : ln_inc_str;
        case (ln_case)
          mlr_pkg::CASE_SHALLOW_RISE: begin ln_x += 1; if (diag) ln_y += 1; end
          mlr_pkg::CASE_STEEP_RISE:   begin ln_y += 1; if (diag) ln_x += 1; end
          mlr_pkg::CASE_SHALLOW_FALL: begin ln_x -= 1; if (diag) ln_y += 1; end
          default:                    begin ln_y += 1; if (diag) ln_x -= 1; end
        endcase
      end
      if (ln_case == mlr_pkg::CASE_SHALLOW_RISE || ln_case == mlr_pkg::CASE_SHALLOW_FALL)
        at_stop = ln_x == ln_stop;
      else
        at_stop = ln_y == ln_stop;
      ln_active = !at_stop;
      px.pixel_x     = ln_x[CW-1:0];
      px.pixel_y     = ln_y[CW-1:0];
      px.pixel_color = ln_color;
      px.pixel_valid = 1'b1;
      px.last_pixel  = at_stop;
      pixel_q.push_back(px);
    end
  endtask

  function automatic mlr_pkg::in_item_t step_beat();
    mlr_pkg::in_item_t b;
    b.func   = mlr_pkg::FUNC_STEP;
    b.from_x = CW'($urandom);
    b.from_y = CW'($urandom);
    b.to_x   = CW'($urandom);
    b.to_y   = CW'($urandom);
    b.color  = CLW'($urandom);
    return b;
  endfunction

  task automatic queue_line(input int x1, input int y1, input int x2, input int y2,
                            input logic [CLW-1:0] col, input int steps);
    mlr_pkg::in_item_t b;
    int                i;
    b.func   = mlr_pkg::FUNC_START;
    b.from_x = x1[CW-1:0];
    b.from_y = y1[CW-1:0];
    b.to_x   = x2[CW-1:0];
    b.to_y   = y2[CW-1:0];
    b.color  = col;
    raster_cmd_q.push_back(b);
    for (i = 0; i < steps; i++) raster_cmd_q.push_back(step_beat());
  endtask

  task automatic check_field(input string fld, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, fld, want, got);
      err_cnt++;
    end
  endtask

  // Driver: hold a stalled beat, otherwise idle in bursts or send the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      src_gap = 0;
    end else begin
      if (in_valid && !in_stall) trace_pixel(in_data);
      if (!(in_valid && in_stall)) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (raster_cmd_q.size() > 200 && $urandom_range(0, 11) == 0) begin
          src_gap = $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else if (raster_cmd_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= raster_cmd_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted pixel beat against the oldest prediction
  always @(posedge clk) begin
    mlr_pkg::out_item_t want_px;
    if (rst) begin
      out_stall <= 1'b0;
      snk_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected pixel beat: expected none, got %p", $time, out_data);
          err_cnt++;
        end else begin
          want_px = pixel_q.pop_front();
          check_field("pixel_x", int'(want_px.pixel_x), int'(out_data.pixel_x));
          check_field("pixel_y", int'(want_px.pixel_y), int'(out_data.pixel_y));
          check_field("pixel_color", int'(want_px.pixel_color),
                      int'(out_data.pixel_color));
          check_field("pixel_valid", int'(want_px.pixel_valid),
                      int'(out_data.pixel_valid));
          check_field("last_pixel", int'(want_px.last_pixel), int'(out_data.last_pixel));
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        out_stall <= 1'b1;
      end else if (raster_cmd_q.size() > 200 && $urandom_range(0, 11) == 0) begin
        snk_gap = $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int len, minor, dx, dy, lo, hi, x1, y1, n, pick;

    raster_cmd_q.push_back(step_beat());                  // step before any line
    queue_line(2047, -2048, 2047, -2048, 24'hFFFFFF, 1);  // single point, then idle step
    queue_line(5, -1, 3, -1, 24'h000000, 2);              // horizontal, reversed
    queue_line(-2048, 2, -2048, 0, 24'h123456, 2);        // vertical, reversed
    queue_line(3, 3, 0, 0, 24'hA5A5A5, 3);                // 45 degrees rising, reversed
    queue_line(0, 0, -2, 2, 24'h5A5A5A, 2);               // 45 degrees falling
    queue_line(1, 0, 0, 3, 24'h0F0F0F, 3);                // steep falling
    queue_line(-2048, -2048, 2047, 2047, 24'h000000, 2);  // full span, dropped early
    queue_line(2047, -2048, -2048, 2047, 24'hFFFFFF, 1);

    while (raster_cmd_q.size() < 1750) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) len = $urandom_range(0, 15);
      else if (pick < 96) len = $urandom_range(16, 100);
      else len = $urandom_range(101, 400);
      minor = $urandom_range(0, len);
      if ($urandom_range(0, 1)) begin
        dx = len; dy = minor;
      end else begin
        dx = minor; dy = len;
      end
      if ($urandom_range(0, 1)) dx = -dx;
      if ($urandom_range(0, 1)) dy = -dy;
      lo = (dx < 0) ? -2048 - dx : -2048;
      hi = (dx > 0) ? 2047 - dx : 2047;
      x1 = lo + $urandom_range(0, hi - lo);
      lo = (dy < 0) ? -2048 - dy : -2048;
      hi = (dy > 0) ? 2047 - dy : 2047;
      y1 = lo + $urandom_range(0, hi - lo);
      // mostly complete lines, some dropped early, some walked past the end
      pick = $urandom_range(0, 99);
      if (pick < 85) n = len;
      else if (pick < 95) n = $urandom_range(0, len);
      else n = len + $urandom_range(1, 3);
      queue_line(x1, y1, x1 + dx, y1 + dy, CLW'($urandom), n);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (raster_cmd_q.size() != 0 || in_valid) @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
